// ===== hdl/lpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_pkg
// shared types, codes and helpers of the longest prefix route lookup
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int unsigned MAX_ROUTES_DEF = 16;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned LEN_W          = 6;
    localparam int unsigned HOP_W          = 8;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [LEN_W-1:0]  PREFIX_MAX = LEN_W'(32);
    localparam logic [ADDR_W-1:0] ADDR_ONES  = 32'hFFFF_FFFF;

    // opcode values
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_HIT   = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [HOP_W-1:0]  hop_id;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [HOP_W-1:0] next_hop;
        logic [LEN_W-1:0] matched_len;
    } rsp_t;

    // classified command between front and engine
    typedef struct packed {
        logic              is_lookup;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [HOP_W-1:0]  hop;
    } cmd_t;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [LEN_W-1:0]  length;
        logic [HOP_W-1:0]  hop;
    } route_t;

    // length is already saturated to 32; zero gives an empty mask
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        return ~(ADDR_ONES >> len);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lpm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_front
// accepts request words, classifies them and saturates the prefix length
// ----------------------------------------------------------------------------
module lpm_front (
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lpm_pkg::req_t req_word,
    output logic               push,
    input  wire logic          push_ready,
    output lpm_pkg::cmd_t      push_cmd
);

    assign req_ready = push_ready;
    assign push      = req_valid & push_ready;

    always_comb
    begin
        push_cmd.is_lookup = (req_word.opcode == lpm_pkg::OP_LOOKUP);
        push_cmd.address   = req_word.address;
        push_cmd.hop       = req_word.hop_id;
        // lengths above 32 become a host route
        if (req_word.prefix_len > lpm_pkg::PREFIX_MAX)
        begin
            push_cmd.length = lpm_pkg::PREFIX_MAX;
        end
        else
        begin
            push_cmd.length = req_word.prefix_len;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lpm_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_cmd_fifo
// short command queue between front and lookup engine
// ----------------------------------------------------------------------------
module lpm_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               push_ready,
    input  wire lpm_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop,
    output lpm_pkg::cmd_t      pop_cmd
);

    localparam int unsigned PTR_W = (lpm_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(lpm_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(lpm_pkg::QUEUE_DEPTH + 1);

    lpm_pkg::cmd_t    slot_reg [lpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(lpm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lpm_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_engine
// route table memory, add handling and one-entry-per-cycle lookup scan
// ----------------------------------------------------------------------------
module lpm_engine #(
    parameter int unsigned MAX_ROUTES = lpm_pkg::MAX_ROUTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    input  wire lpm_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output lpm_pkg::rsp_t      rsp_word
);

    localparam int unsigned IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ROUTES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic                          rd_vld_reg;
    logic                          found_reg, found_next;
    logic [lpm_pkg::LEN_W-1:0]     best_len_reg, best_len_next;
    logic [lpm_pkg::HOP_W-1:0]     best_hop_reg, best_hop_next;
    logic [lpm_pkg::ADDR_W-1:0]    dest_reg, dest_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    lpm_pkg::rsp_t                 rsp_reg, rsp_next;

    lpm_pkg::route_t               route_mem [MAX_ROUTES];
    lpm_pkg::route_t               rd_data_reg;

    logic                          take, table_full, wr_en, rd_en, scan_done;
    logic                          entry_hit, entry_better;

    assign take       = (state_reg == S_IDLE) && cmd_valid && !rsp_valid_reg;
    assign cmd_pop    = take;
    assign table_full = (count_reg == CNT_W'(MAX_ROUTES));
    assign wr_en      = take && !cmd.is_lookup && !table_full;
    assign rd_en      = (state_reg == S_SCAN) && (issue_reg != count_reg);
    assign scan_done  = (state_reg == S_SCAN) && !rd_en && !rd_vld_reg;

    // masked compare of the entry read last cycle
    assign entry_hit = rd_vld_reg &&
        (((dest_reg ^ rd_data_reg.network) & lpm_pkg::prefix_mask(rd_data_reg.length))
         == '0);
    assign entry_better = entry_hit && (!found_reg || (rd_data_reg.length > best_len_reg));

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_hop_next  = best_hop_reg;
        dest_next      = dest_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (cmd.is_lookup)
                    begin
                        dest_next  = cmd.address;
                        issue_next = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rsp_next.next_hop    = '0;
                        rsp_next.matched_len = '0;
                        rsp_valid_next       = 1'b1;
                        if (table_full)
                        begin
                            rsp_next.status = lpm_pkg::ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status = lpm_pkg::ST_ADDED;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (entry_better)
                begin
                    found_next    = 1'b1;
                    best_len_next = rd_data_reg.length;
                    best_hop_next = rd_data_reg.hop;
                end
                if (scan_done)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (found_reg)
                    begin
                        rsp_next.status      = lpm_pkg::ST_HIT;
                        rsp_next.next_hop    = best_hop_reg;
                        rsp_next.matched_len = best_len_reg;
                    end
                    else
                    begin
                        rsp_next.status      = lpm_pkg::ST_MISS;
                        rsp_next.next_hop    = '0;
                        rsp_next.matched_len = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_en;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_len_reg <= best_len_next;
        best_hop_reg <= best_hop_next;
        dest_reg     <= dest_next;
        rsp_reg      <= rsp_next;
    end

    // route table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_mem[count_reg[IDX_W-1:0]] <= '{network: cmd.address,
                                                 length:  cmd.length,
                                                 hop:     cmd.hop};
        end
        if (rd_en)
        begin
            rd_data_reg <= route_mem[issue_reg[IDX_W-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/longest_prefix_route_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// ipv4 route table with add and longest prefix match lookup
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req_word) takes one word per item:
//   opcode add stores address/prefix_len/hop_id in the next free slot,
//   opcode lookup searches the table for address
//   rsp channel (rsp_valid/rsp_ready/rsp_word) returns exactly one word per
//   item, in order: added, full, hit (next_hop, matched_len) or miss
// timing
//   a front stage feeds a 2-entry command queue; the engine behind it takes
//   one command at a time
//   add: the engine answers from its response register and takes no new
//   command until that response is taken; lookup: scans one stored route
//   per cycle from the table memory through a registered read port, then
//   loads the best match into the response register
// reset
//   rst_n clears the route count and all control; the table needs no clear
// stalls
//   a held response sits in the output register while the queue keeps
//   taking up to two more request words; then req_ready drops
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup #(
    parameter int unsigned MAX_ROUTES = lpm_pkg::MAX_ROUTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lpm_pkg::req_t req_word,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output lpm_pkg::rsp_t      rsp_word
);

    // front to queue
    logic          push, push_ready;
    lpm_pkg::cmd_t push_cmd;
    // queue to engine
    logic          pop_valid, pop;
    lpm_pkg::cmd_t pop_cmd;

    // classify and saturate the prefix
    lpm_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_word   (req_word),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouples acceptance from the scan
    lpm_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // table memory, add and sequential match scan, response register
    lpm_engine #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_pop    (pop),
        .cmd        (pop_cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word)
    );

endmodule
`default_nettype wire

// ===== hdl/lpm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_checker
// port level checks of the route lookup, bound to the top level
// ----------------------------------------------------------------------------
module lpm_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire lpm_pkg::req_t req_word,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire lpm_pkg::rsp_t rsp_word
);

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("response changed while stalled");

    // add results carry no hop or length
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == lpm_pkg::ST_ADDED ||
                      rsp_word.status == lpm_pkg::ST_FULL)
        |-> rsp_word.next_hop == '0 && rsp_word.matched_len == '0)
        else $error("add response with nonzero payload");

    // a miss carries no hop or length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == lpm_pkg::ST_MISS
        |-> rsp_word.next_hop == '0 && rsp_word.matched_len == '0)
        else $error("miss response with nonzero payload");

    // matched length never beyond a host route
    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == lpm_pkg::ST_HIT
        |-> rsp_word.matched_len <= lpm_pkg::PREFIX_MAX)
        else $error("hit with prefix length above 32");

    // a waiting request word stays put
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_word))
        else $error("request changed while waiting");

endmodule

bind longest_prefix_route_lookup lpm_checker u_lpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the longest prefix route lookup: fills the route
// table through directed adds that cover saturated, zero and duplicate
// prefixes, overflows it, then sends random lookups aimed at the stored
// routes, near misses and edge addresses. Every response word is checked
// against an in-bench route table model under random stalls on both sides.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned TABLE_SLOTS = lpm_pkg::MAX_ROUTES_DEF;
    // the receiver stalls once for this long so the input queue backs up
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 150;
    localparam int unsigned RAND_BATCH  = 260;
    // margin for a lookup on a full table in the engine, plus the front
    localparam int unsigned TAIL_CYCLES = 40;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    lpm_pkg::req_t req_word  = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    lpm_pkg::rsp_t rsp_word;

    always #5 clk = ~clk;

    longest_prefix_route_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    // shadow copy of the route table, filled in acceptance order
    logic [lpm_pkg::ADDR_W-1:0] shadow_net [TABLE_SLOTS];
    logic [lpm_pkg::LEN_W-1:0]  shadow_len [TABLE_SLOTS];
    logic [lpm_pkg::HOP_W-1:0]  shadow_hop [TABLE_SLOTS];
    int unsigned                shadow_used = 0;

    lpm_pkg::req_t word_q[$];      // request words not yet offered
    lpm_pkg::rsp_t answer_q[$];    // predicted response words, oldest first

    int unsigned mismatches = 0;
    int unsigned n_added    = 0;
    int unsigned n_full     = 0;
    int unsigned n_hit      = 0;
    int unsigned n_miss     = 0;
    int unsigned n_checked  = 0;

    // sender and receiver pacing
    int unsigned   send_gap  = 0;
    int unsigned   send_calm = 0;
    int unsigned   recv_wait = 0;
    int unsigned   recv_calm = 0;
    int unsigned   hold_left = 0;
    logic          hold_done = 1'b0;
    lpm_pkg::rsp_t want;

    // ------------------------------------------------------------------------
    // route table model
    // ------------------------------------------------------------------------

    // mask of the top len bits; len is at most 32 here
    function automatic logic [lpm_pkg::ADDR_W-1:0] net_mask(
        input logic [lpm_pkg::LEN_W-1:0] len);
        if (len == '0)
            return '0;
        return {lpm_pkg::ADDR_W{1'b1}} << (lpm_pkg::ADDR_W - int'(len));
    endfunction

    // apply one accepted word to the shadow table and return its response
    function automatic lpm_pkg::rsp_t route_table_apply(input lpm_pkg::req_t w);
        lpm_pkg::rsp_t              r;
        logic [lpm_pkg::LEN_W-1:0]  len;
        logic [lpm_pkg::ADDR_W-1:0] m;
        logic                       found;
        r.status      = lpm_pkg::ST_MISS;
        r.next_hop    = '0;
        r.matched_len = '0;
        found         = 1'b0;
        if (w.opcode == lpm_pkg::OP_ADD)
        begin
            if (shadow_used >= TABLE_SLOTS)
            begin
                // table full: nothing stored
                r.status = lpm_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                // lengths above 32 saturate, host bits are kept as given
                len = (w.prefix_len > lpm_pkg::PREFIX_MAX) ? lpm_pkg::PREFIX_MAX
                                                           : w.prefix_len;
                shadow_net[shadow_used] = w.address;
                shadow_len[shadow_used] = len;
                shadow_hop[shadow_used] = w.hop_id;
                shadow_used++;
                r.status = lpm_pkg::ST_ADDED;
                n_added++;
            end
        end
        else
        begin
            // strictly longer wins, so the earliest route keeps a tie
            for (int unsigned i = 0; i < shadow_used; i++)
            begin
                m = net_mask(shadow_len[i]);
                if ((w.address & m) == (shadow_net[i] & m) &&
                    (!found || shadow_len[i] > r.matched_len))
                begin
                    found         = 1'b1;
                    r.matched_len = shadow_len[i];
                    r.next_hop    = shadow_hop[i];
                end
            end
            if (found)
            begin
                r.status = lpm_pkg::ST_HIT;
                n_hit++;
            end
            else
            begin
                n_miss++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_add(input logic [lpm_pkg::ADDR_W-1:0] a,
                             input logic [lpm_pkg::LEN_W-1:0] len,
                             input logic [lpm_pkg::HOP_W-1:0] hop);
        lpm_pkg::req_t w;
        w.opcode     = lpm_pkg::OP_ADD;
        w.address    = a;
        w.prefix_len = len;
        w.hop_id     = hop;
        word_q       = {word_q, w};
    endtask

    // length and hop are ignored on lookup, so they carry noise
    task automatic queue_lookup(input logic [lpm_pkg::ADDR_W-1:0] a);
        lpm_pkg::req_t w;
        w.opcode     = lpm_pkg::OP_LOOKUP;
        w.address    = a;
        w.prefix_len = lpm_pkg::LEN_W'($urandom_range(0, 63));
        w.hop_id     = lpm_pkg::HOP_W'($urandom_range(0, 255));
        word_q       = {word_q, w};
    endtask

    // lookup address: mostly inside a stored route, some one bit outside
    // its prefix, some all-zero or all-one, the rest fully random
    function automatic logic [lpm_pkg::ADDR_W-1:0] probe_address();
        int unsigned                pick;
        int unsigned                slot;
        int unsigned                edge_bit;
        logic [lpm_pkg::ADDR_W-1:0] m;
        logic [lpm_pkg::ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        a    = $urandom;
        if (pick < 60 && shadow_used != 0)
        begin
            slot = $urandom_range(0, shadow_used - 1);
            m    = net_mask(shadow_len[slot]);
            a    = (shadow_net[slot] & m) | (a & ~m);
            if (pick < 15 && shadow_len[slot] != '0)
            begin
                edge_bit    = lpm_pkg::ADDR_W - int'(shadow_len[slot]);
                a[edge_bit] = ~a[edge_bit];
            end
        end
        else if (pick < 70)
        begin
            a = pick[0] ? {lpm_pkg::ADDR_W{1'b1}} : '0;
        end
        return a;
    endfunction

    // table is full by now, so adds here all come back as full
    task automatic queue_random(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 12)
                queue_add($urandom, lpm_pkg::LEN_W'($urandom_range(0, 63)),
                          lpm_pkg::HOP_W'($urandom_range(0, 255)));
            else
                queue_lookup(probe_address());
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (word_q.size() != 0 || req_valid || answer_q.size() != 0)
            @(negedge clk);
    endtask

    // gap length: mostly none, some short, a few long, with calm stretches
    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued words, predicts each one at acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                answer_q = {answer_q, route_table_apply(req_word)};
            // the current word is gone (or there was none): pick what comes next
            if (!req_valid || req_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (word_q.size() != 0)
                begin
                    req_word  <= word_q.pop_front();
                    req_valid <= 1'b1;
                    send_gap  = idle_len(send_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted on its own once enough words are back
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_checked >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks response words and paces rsp_ready
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_checked++;
                if (answer_q.size() == 0)
                begin
                    flag_error($sformatf("response word with nothing outstanding: %p",
                                         rsp_word));
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_word.status !== want.status)
                        flag_error($sformatf("status expected %s got %0d",
                                             want.status.name(), rsp_word.status));
                    if (rsp_word.next_hop !== want.next_hop)
                        flag_error($sformatf("next_hop expected %0d got %0d",
                                             want.next_hop, rsp_word.next_hop));
                    if (rsp_word.matched_len !== want.matched_len)
                        flag_error($sformatf("matched_len expected %0d got %0d",
                                             want.matched_len, rsp_word.matched_len));
                end
            end
            // during the hold-off the sender keeps offering, so the output
            // register and the command queue fill and req_ready drops
            if (hold_left != 0)
            begin
                rsp_ready <= 1'b0;
            end
            else if (recv_wait != 0)
            begin
                recv_wait--;
                rsp_ready <= 1'b0;
            end
            else if (rsp_valid && rsp_ready)
            begin
                // new stall drawn after each taken word
                recv_wait = idle_len(recv_calm);
                if (recv_wait != 0)
                begin
                    recv_wait--;
                    rsp_ready <= 1'b0;
                end
                else
                begin
                    rsp_ready <= 1'b1;
                end
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table misses everything
        queue_lookup(32'h0000_0000);
        queue_lookup(32'hFFFF_FFFF);
        // nested prefixes, the last one saturated from 40 to 32
        queue_add(32'h0A00_0000, lpm_pkg::LEN_W'(8), 8'd1);
        queue_add(32'h0A01_0000, lpm_pkg::LEN_W'(16), 8'd2);
        queue_add(32'h0A01_0200, lpm_pkg::LEN_W'(24), 8'd3);
        queue_add(32'h0A01_0203, lpm_pkg::LEN_W'(40), 8'd4);
        queue_lookup(32'h0A01_0203);
        queue_lookup(32'h0A01_0204);
        queue_lookup(32'h0A09_0909);
        queue_lookup(32'h0B00_0000);
        // default route with host bits set in the stored network
        queue_add(32'hDEAD_BEEF, lpm_pkg::LEN_W'(0), 8'hFF);
        queue_lookup(32'h0B00_0000);
        // same /16 again: the earlier entry must keep winning
        queue_add(32'h0A01_FFFF, lpm_pkg::LEN_W'(16), 8'd6);
        queue_lookup(32'h0A01_0505);
        // all-ones host route at the widest length code
        queue_add(32'hFFFF_FFFF, lpm_pkg::LEN_W'(63), 8'd0);
        queue_lookup(32'hFFFF_FFFF);
        queue_add(32'hC0A8_014D, lpm_pkg::LEN_W'(24), 8'h80);
        queue_add(32'hC0A8_0100, lpm_pkg::LEN_W'(32), 8'h7F);
        // fill the remaining slots
        for (int unsigned k = 0; k < TABLE_SLOTS - 9; k++)
            queue_add($urandom, lpm_pkg::LEN_W'($urandom_range(1, 31)),
                      lpm_pkg::HOP_W'($urandom_range(0, 255)));
        // table full: dropped
        queue_add(32'h0102_0304, lpm_pkg::LEN_W'(63), 8'hFF);
        queue_lookup(32'hC0A8_0101);

        // sender pauses until every response is back
        wait_drained();
        queue_random(RAND_BATCH);
        wait_drained();
        queue_random(RAND_BATCH);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("adds: %0d stored, %0d dropped on a full table; lookups: %0d hit, %0d miss",
                 n_added, n_full, n_hit, n_miss);
        $display("%0d response words checked under random stalls and one %0d-cycle hold",
                 n_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d response words outstanding", answer_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
